@@ hw/rtl/psta_pkg.sv @@
`default_nettype none
package psta_pkg;

  // converter resolution; only the low ADC_BITS bits of a reading are used
  localparam int ADC_BITS  = 10;
  localparam int FROM_W    = 16;
  localparam int TO_W      = 15;
  localparam int LIMIT_W   = 16;
  localparam int TICK_W    = 32;
  localparam int EN_W      = 2;
  localparam int PROD_W    = FROM_W + TO_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MUL_CNT_W = $clog2(TO_W);
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FROM_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FROM_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TO_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TO_HIGH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLES = 3'd7;

  // reset values
  localparam logic [FROM_W-1:0]  RST_FROM_LOW      = 16'd0;
  localparam logic [FROM_W-1:0]  RST_FROM_HIGH     = 16'd1023;
  localparam logic [TO_W-1:0]    RST_TO_LOW        = 15'd0;
  localparam logic [TO_W-1:0]    RST_TO_HIGH       = 15'd1023;
  localparam logic [LIMIT_W-1:0] RST_LOWER_LIMIT   = 16'd0;
  localparam logic [LIMIT_W-1:0] RST_UPPER_LIMIT   = 16'hFFFF;
  localparam logic [TICK_W-1:0]  RST_READ_INTERVAL = 32'd0;
  localparam logic [EN_W-1:0]    RST_ALARM_ENABLES = 2'd0;

  localparam int EN_LOWER = 0;
  localparam int EN_UPPER = 1;

endpackage
`default_nettype wire

@@ hw/rtl/psta_if.sv @@
`default_nettype none
interface psta_tick_if import psta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface psta_result_if import psta_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            sampled;
  logic [TO_W-1:0] scaled_value;
  logic            lower_alarm;
  logic            upper_alarm;

  modport source (output valid, output sampled, output scaled_value,
                  output lower_alarm, output upper_alarm, input ready);
  modport sink   (input valid, input sampled, input scaled_value,
                  input lower_alarm, input upper_alarm, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/psta_mul.sv @@
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module psta_mul import psta_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [FROM_W-1:0] a,
  input  wire logic [TO_W-1:0]   b,
  output logic                   done,
  output logic [PROD_W-1:0]      product
);

  logic [FROM_W-1:0]    a_q;
  logic [TO_W-1:0]      b_sh;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [PROD_W-1:0]    addend;

  assign addend = b_sh[TO_W-1] ? PROD_W'(a_q) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(TO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q     <= a;
      b_sh    <= b;
      product <= '0;
    end else if (busy) begin
      product <= {product[PROD_W-2:0], 1'b0} + addend;
      b_sh    <= {b_sh[TO_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/psta_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module psta_div import psta_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [FROM_W-1:0] divisor,
  output logic                   done,
  output logic [PROD_W-1:0]      quotient
);

  logic [FROM_W-1:0]    dvs;
  logic [FROM_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [FROM_W:0]      rem_sh;
  logic [FROM_W+1:0]    diff;
  logic                 ge;

  // quotient register doubles as the dividend shifter
  assign rem_sh = {rem, quotient[PROD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = ~diff[FROM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[FROM_W-1:0] : rem_sh[FROM_W-1:0];
      quotient <= {quotient[PROD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/periodic_sample_scale_threshold_alarm.sv @@
`default_nettype none
// Periodic sampler with linear range map and threshold alarms. Each transfer
// on tick is one millisecond tick with the current converter reading; each
// tick gives exactly one transfer on result. A saturating tick counter runs
// since the last sample; when it exceeds read_interval the reading is mapped
// (raw-from_low)*(to_high-to_low)/(from_high-from_low)+to_low with exact
// intermediates and truncation toward zero, clamped to [to_low, to_high]
// (if the range is inverted, a value below to_low gives to_low and any other
// gives to_high), and checked against the two alarm limits. An empty source
// range maps to to_low before the clamp. Each enabled alarm pulses once when
// the value crosses its limit and rearms when it comes back. A tick that
// takes no sample goes straight to the finish step, which loads the output
// register and returns to idle. A sample with an empty source range skips
// the arithmetic and runs only the clamp, alarm and finish steps. Any other
// sampling tick runs, in order: register the operands, load the multiplier,
// the bit-serial multiplier (one bit of |to_high-to_low| per cycle), load
// the divider, the restoring divider (one quotient bit per cycle), then
// the sum, clamp, alarm and output steps. A stalled result holds the block
// in its finish step until the output register is free. One tick is
// in work at a time; tick.ready is high while the block is idle, even when
// the previous result still waits in the output register. Configuration
// writes are taken at any time but must only be issued while the block is
// idle.
module periodic_sample_scale_threshold_alarm import psta_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  psta_tick_if.sink                 tick,
  psta_result_if.source             result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_CLAMP  = 3'd3;
  localparam logic [2:0] ST_ALARM  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  // configuration registers
  logic [FROM_W-1:0]  from_low;
  logic [FROM_W-1:0]  from_high;
  logic [TO_W-1:0]    to_low;
  logic [TO_W-1:0]    to_high;
  logic [LIMIT_W-1:0] lower_limit;
  logic [LIMIT_W-1:0] upper_limit;
  logic [TICK_W-1:0]  read_interval;
  logic [EN_W-1:0]    alarm_enables;

  // block state
  logic [2:0]         state;
  logic [TICK_W-1:0]  ticks_since_read;
  logic               lower_fired;
  logic               upper_fired;
  logic [TO_W-1:0]    last_scaled;

  // per-tick datapath
  logic [FROM_W-1:0]  op_a;     // |raw - from_low|
  logic [TO_W-1:0]    op_b;     // |to_high - to_low|
  logic [FROM_W-1:0]  op_d;     // |from_high - from_low|
  logic               neg;      // sign of the quotient
  logic [SUM_W-1:0]   sum;      // to_low + |quotient|
  logic               q_nz;
  logic [TO_W-1:0]    val;

  // pending result
  logic               res_sampled;
  logic               res_lo;
  logic               res_hi;

  logic                tick_xfer;
  logic                result_xfer;
  logic [FROM_W-1:0]   raw_x;
  logic [TICK_W-1:0]   ticks_inc;
  logic                take;
  logic                x_neg;
  logic                t_neg;
  logic                d_neg;
  logic                den_zero;
  logic                mul_kick;
  logic                mul_start;
  logic                mul_done;
  logic [PROD_W-1:0]   product;
  logic                div_start;
  logic                div_done;
  logic [PROD_W-1:0]   quotient;
  logic [TO_W-1:0]     val_next;
  logic                below;
  logic                above;

  assign tick.ready  = (state == ST_IDLE);
  assign tick_xfer   = tick.valid & tick.ready;
  assign result_xfer = result.valid & result.ready;

  // tick counter saturates at all ones, so read_interval of all ones never samples
  assign ticks_inc = (&ticks_since_read) ? ticks_since_read : ticks_since_read + 1'b1;
  assign take      = ticks_inc > read_interval;

  // sign-magnitude split of the three differences
  assign raw_x    = FROM_W'(tick.raw_sample);
  assign x_neg    = raw_x < from_low;
  assign t_neg    = to_high < to_low;
  assign d_neg    = from_high < from_low;
  assign den_zero = (from_high == from_low);

  // multiplier starts once op_a/op_b hold this tick's operands
  assign mul_start = mul_kick;
  assign div_start = (state == ST_MUL) & mul_done;

  psta_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (op_a),
    .b       (op_b),
    .done    (mul_done),
    .product (product)
  );

  psta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (op_d),
    .done     (div_done),
    .quotient (quotient)
  );

  // negative nonzero quotient lands below to_low; otherwise sum >= to_low
  always_comb begin
    if (neg && q_nz) begin
      val_next = to_low;
    end else if (sum > SUM_W'(to_high)) begin
      val_next = to_high;
    end else begin
      val_next = sum[TO_W-1:0];
    end
  end

  assign below = LIMIT_W'(val) < lower_limit;
  assign above = LIMIT_W'(val) > upper_limit;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      from_low      <= RST_FROM_LOW;
      from_high     <= RST_FROM_HIGH;
      to_low        <= RST_TO_LOW;
      to_high       <= RST_TO_HIGH;
      lower_limit   <= RST_LOWER_LIMIT;
      upper_limit   <= RST_UPPER_LIMIT;
      read_interval <= RST_READ_INTERVAL;
      alarm_enables <= RST_ALARM_ENABLES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FROM_LOW:      from_low      <= cfg_data[FROM_W-1:0];
        REG_FROM_HIGH:     from_high     <= cfg_data[FROM_W-1:0];
        REG_TO_LOW:        to_low        <= cfg_data[TO_W-1:0];
        REG_TO_HIGH:       to_high       <= cfg_data[TO_W-1:0];
        REG_LOWER_LIMIT:   lower_limit   <= cfg_data[LIMIT_W-1:0];
        REG_UPPER_LIMIT:   upper_limit   <= cfg_data[LIMIT_W-1:0];
        REG_READ_INTERVAL: read_interval <= cfg_data[TICK_W-1:0];
        REG_ALARM_ENABLES: alarm_enables <= cfg_data[EN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ticks_since_read <= '0;
      lower_fired      <= 1'b0;
      upper_fired      <= 1'b0;
      last_scaled      <= '0;
      result.valid     <= 1'b0;
      mul_kick         <= 1'b0;
    end else begin
      mul_kick <= tick_xfer & take & ~den_zero;
      if (result_xfer) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tick_xfer) begin
            ticks_since_read <= take ? '0 : ticks_inc;
            if (!take) begin
              state <= ST_FINISH;
            end else if (den_zero) begin
              state <= ST_CLAMP;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          state <= ST_ALARM;
        end
        ST_ALARM: begin
          last_scaled <= val;
          if (alarm_enables[EN_LOWER]) begin
            lower_fired <= below;
          end
          if (alarm_enables[EN_UPPER]) begin
            upper_fired <= above;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      op_a        <= x_neg ? from_low - raw_x : raw_x - from_low;
      op_b        <= t_neg ? to_low - to_high : to_high - to_low;
      op_d        <= d_neg ? from_low - from_high : from_high - from_low;
      neg         <= x_neg ^ t_neg ^ d_neg;
      sum         <= SUM_W'(to_low);
      q_nz        <= 1'b0;
      res_sampled <= take;
      res_lo      <= 1'b0;
      res_hi      <= 1'b0;
    end
    if (state == ST_DIV && div_done) begin
      sum  <= SUM_W'(to_low) + SUM_W'(quotient);
      q_nz <= |quotient;
    end
    if (state == ST_CLAMP) begin
      val <= val_next;
    end
    if (state == ST_ALARM) begin
      res_lo <= alarm_enables[EN_LOWER] & below & ~lower_fired;
      res_hi <= alarm_enables[EN_UPPER] & above & ~upper_fired;
    end
    if (state == ST_FINISH && (!result.valid || result.ready)) begin
      result.sampled      <= res_sampled;
      result.scaled_value <= last_scaled;
      result.lower_alarm  <= res_lo;
      result.upper_alarm  <= res_hi;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/psta_checker.sv @@
`default_nettype none
module psta_checker import psta_pkg::*; (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            tick_valid,
  input wire logic            tick_ready,
  input wire logic            result_valid,
  input wire logic            result_ready,
  input wire logic            sampled,
  input wire logic [TO_W-1:0] scaled_value,
  input wire logic            lower_alarm,
  input wire logic            upper_alarm
);

  // one tick in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> !tick_ready)
    else $error("tick taken while another is in work");

  // alarms only pulse on sampling ticks
  a_alarm_needs_sample: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (lower_alarm || upper_alarm)) |-> sampled)
    else $error("alarm pulse without a sample");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(sampled) && $stable(scaled_value) &&
       $stable(lower_alarm) && $stable(upper_alarm)))
    else $error("stalled result changed");

  // nothing is offered right out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind periodic_sample_scale_threshold_alarm psta_checker u_psta_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .sampled      (result.sampled),
  .scaled_value (result.scaled_value),
  .lower_alarm  (result.lower_alarm),
  .upper_alarm  (result.upper_alarm)
);
`default_nettype wire
